/* rtl/vht_pkg.sv */
// Shared types and constants of the hysteresis VAD timeline block.
// No dependencies; the two interfaces and the core import this package.
package vht_pkg;

    // Field widths
    localparam int PROB_BITS  = 16;
    localparam int LEVEL_W    = 16;
    localparam int SAMP_W     = 13;
    localparam int FRAME_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    // (window counter + 1) times window length
    localparam int PROD_W     = FRAME_W + 1 + SAMP_W;

    // Register reset values
    localparam logic [LEVEL_W-1:0] ONSET_RST  = 16'd32768;
    localparam logic [LEVEL_W-1:0] OFFSET_RST = 16'd22938;
    localparam logic [SAMP_W-1:0]  HOP_RST    = 13'd160;
    localparam logic [SAMP_W-1:0]  WIN_RST    = 13'd512;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd3;

    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

    typedef enum logic [1:0] {
        OP_WINDOW  = 2'd0,
        OP_QUERY   = 2'd1,
        OP_DISCARD = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV0,
        S_DIV1,
        S_PLAN_A,
        S_PLAN_B,
        S_PLAN_C,
        S_FILL,
        S_WUPD,
        S_QRD,
        S_FINISH
    } st_t;

endpackage

/* rtl/vht_req_if.sv */
// Request channel of the VAD timeline block: operation, probability, frame index.
// Depends on vht_pkg.
interface vht_req_if;
    import vht_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [PROB_BITS-1:0] prob;
    logic [FRAME_W-1:0]   frame_index;

    modport source (output valid, output op, output prob, output frame_index, input ready);
    modport sink   (input valid, input op, input prob, input frame_index, output ready);
endinterface

/* rtl/vht_rsp_if.sv */
// Result channel of the VAD timeline block: query flag, speech state and timeline bounds.
// Depends on vht_pkg.
interface vht_rsp_if;
    import vht_pkg::*;

    logic               valid;
    logic               ready;
    logic               query_speech;
    logic               in_speech;
    logic               overflow;
    logic               last_speech_valid;
    logic [FRAME_W-1:0] last_speech_frame;
    logic [FRAME_W-1:0] timeline_start;
    logic [FRAME_W-1:0] timeline_end;

    modport source (
        output valid, output query_speech, output in_speech, output overflow,
        output last_speech_valid, output last_speech_frame, output timeline_start,
        output timeline_end, input ready
    );
    modport sink (
        input valid, input query_speech, input in_speech, input overflow,
        input last_speech_valid, input last_speech_frame, input timeline_start,
        input timeline_end, output ready
    );
endinterface

/* rtl/vht_div.sv */
// Shared restoring divider: one quotient bit per cycle, quotient out.
// Standalone; used for frame mapping.
module vht_div #(
    parameter int DVD_W = 46,
    parameter int DVS_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quot
);
    localparam int CW = $clog2(DVD_W);

    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] r_reg, r_next;
    logic [DVS_W-1:0] d_reg, d_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;

    // Shift the next dividend bit into the partial remainder
    assign trial = {r_reg, q_reg[DVD_W-1]};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Subtract when the divisor fits, else keep the shifted remainder
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DVS_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DVS_W-1:0];
                q_next = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath holds no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

/* rtl/vht_store.sv */
// One-bit ring store of frame speech flags: one write port, one registered read port.
// Standalone; contents are undefined until written.
module vht_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);
    logic mem [DEPTH];
    logic rdata_reg;

    // Write one frame flag
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/vad_hysteresis_timeline_core.sv */
// Hysteresis VAD binariser with a ring timeline of frame flags. One request at a time.
// Window: hysteresis update, then two frame-bound divides on the shared divider map
//   the window, and N frames are written (gap and window, N <= TIMELINE_DEPTH).
// Query: inside the stored range the flag is read from the store, outside it the result
//   is direct; discard and clear go straight to the result. The next request is taken in idle.
// Reset clears state and loads register defaults; the flag store needs no clearing pass.
module vad_hysteresis_timeline_core #(
    parameter int TIMELINE_DEPTH = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vht_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vht_pkg::CFG_DATA_W-1:0]     cfg_data,
    vht_req_if.sink                            req,
    vht_rsp_if.source                          rsp
);
    import vht_pkg::*;

    // Ring store at the next power-of-two depth: any TIMELINE_DEPTH consecutive
    // frames land on distinct entries, so the low frame bits address it
    localparam int AW          = $clog2(TIMELINE_DEPTH);
    localparam int STORE_DEPTH = 1 << AW;
    localparam int DVS_W       = SAMP_W;
    localparam logic [FRAME_W:0]   DEPTH_33  = (FRAME_W + 1)'(TIMELINE_DEPTH);

    // Configuration registers
    logic [LEVEL_W-1:0] onset_reg, offset_reg;
    logic [SAMP_W-1:0]  hop_reg, win_reg;

    // Sequencer and state
    st_t                  state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [PROB_BITS-1:0] prob_reg, prob_next;
    logic [FRAME_W-1:0]   g_reg, g_next;
    logic                 speech_reg, speech_next;
    logic [FRAME_W-1:0]   wcnt_reg, wcnt_next;
    logic [FRAME_W-1:0]   base_reg, base_next;
    logic [FRAME_W-1:0]   end_reg, end_next;
    logic [FRAME_W-1:0]   last_reg, last_next;
    logic                 seen_reg, seen_next;
    logic [PROD_W-1:0]    f0_reg, f0_next;
    logic [PROD_W-1:0]    f1_reg, f1_next;
    logic [FRAME_W-1:0]   lim_reg, lim_next;
    logic [FRAME_W-1:0]   stop_reg, stop_next;
    logic [FRAME_W-1:0]   f_reg, f_next;
    logic                 q_reg, q_next;
    logic                 ovf_reg, ovf_next;

    // Result register
    logic               ovalid_reg, ovalid_next;
    logic               oq_reg, oq_next;
    logic               ospeech_reg, ospeech_next;
    logic               oovf_reg, oovf_next;
    logic               oseen_reg, oseen_next;
    logic [FRAME_W-1:0] olast_reg, olast_next;
    logic [FRAME_W-1:0] ostart_reg, ostart_next;
    logic [FRAME_W-1:0] oend_reg, oend_next;

    // Shared units
    logic [FRAME_W:0]   mul_k;
    logic [PROD_W-1:0]  mul_p;
    logic               div_start;
    logic [PROD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [PROD_W-1:0]  div_quot;
    logic [DVS_W-1:0]   hop_eff;
    logic               mem_we;
    logic               mem_wdata;
    logic               mem_re;
    logic               mem_rdata;

    // Working values of the planning states
    logic [FRAME_W:0]   lim_sum;
    logic [PROD_W-1:0]  fs_w;
    logic [PROD_W-1:0]  f1m1;

    // Window start uses k, window end uses k + 1
    assign mul_k   = (state_reg == S_DIV0) ? ({1'b0, wcnt_reg} + (FRAME_W + 1)'(1))
                                           : {1'b0, wcnt_reg};
    assign mul_p   = PROD_W'(mul_k) * PROD_W'(win_reg);
    assign hop_eff = (hop_reg == '0) ? DVS_W'(1) : DVS_W'(hop_reg);
    assign lim_sum = {1'b0, base_reg} + DEPTH_33;
    assign f1m1    = f1_reg - PROD_W'(1);

    // First frame to write: from the stored end when a gap opens, else the later of window start and timeline start
    always_comb
    begin
        if (PROD_W'(end_reg) < f0_reg)
        begin
            fs_w = PROD_W'(end_reg);
        end
        else if (f0_reg > PROD_W'(base_reg))
        begin
            fs_w = f0_reg;
        end
        else
        begin
            fs_w = PROD_W'(base_reg);
        end
    end

    vht_div #(
        .DVD_W (PROD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot)
    );

    vht_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (f_reg[AW-1:0]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (g_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    // Sequencer: next state, datapath updates and unit controls
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        prob_next    = prob_reg;
        g_next       = g_reg;
        speech_next  = speech_reg;
        wcnt_next    = wcnt_reg;
        base_next    = base_reg;
        end_next     = end_reg;
        last_next    = last_reg;
        seen_next    = seen_reg;
        f0_next      = f0_reg;
        f1_next      = f1_reg;
        lim_next     = lim_reg;
        stop_next    = stop_reg;
        f_next       = f_reg;
        q_next       = q_reg;
        ovf_next     = ovf_reg;
        ovalid_next  = ovalid_reg;
        oq_next      = oq_reg;
        ospeech_next = ospeech_reg;
        oovf_next    = oovf_reg;
        oseen_next   = oseen_reg;
        olast_next   = olast_reg;
        ostart_next  = ostart_reg;
        oend_next    = oend_reg;
        div_start    = 1'b0;
        div_dvd      = mul_p;
        div_dvs      = hop_eff;
        mem_we       = 1'b0;
        mem_wdata    = 1'b0;
        mem_re       = 1'b0;

        // Drop the result once taken
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    prob_next  = req.prob;
                    g_next     = req.frame_index;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                q_next   = 1'b0;
                ovf_next = 1'b0;
                case (op_reg)
                    OP_WINDOW:
                    begin
                        // Hysteresis update, then map the window start to a frame
                        if (prob_reg > onset_reg[PROB_BITS-1:0])
                        begin
                            speech_next = 1'b1;
                        end
                        else if (prob_reg < offset_reg[PROB_BITS-1:0])
                        begin
                            speech_next = 1'b0;
                        end
                        div_start  = 1'b1;
                        state_next = S_DIV0;
                    end
                    OP_QUERY:
                    begin
                        if (g_reg < base_reg)
                        begin
                            q_next     = 1'b0;
                            state_next = S_FINISH;
                        end
                        else if (g_reg < end_reg)
                        begin
                            mem_re     = 1'b1;
                            state_next = S_QRD;
                        end
                        else
                        begin
                            // Beyond the stored end: provisional current flag
                            q_next     = speech_reg;
                            state_next = S_FINISH;
                        end
                    end
                    OP_DISCARD:
                    begin
                        if (g_reg > base_reg)
                        begin
                            base_next = (g_reg < end_reg) ? g_reg : end_reg;
                        end
                        state_next = S_FINISH;
                    end
                    OP_CLEAR:
                    begin
                        speech_next = 1'b0;
                        wcnt_next   = '0;
                        base_next   = '0;
                        end_next    = '0;
                        last_next   = '0;
                        seen_next   = 1'b0;
                        state_next  = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_DIV0:
            begin
                // Capture the window start and map the window end
                if (div_done)
                begin
                    f0_next    = div_quot;
                    div_start  = 1'b1;
                    state_next = S_DIV1;
                end
            end

            S_DIV1:
            begin
                if (div_done)
                begin
                    f1_next    = div_quot;
                    state_next = S_PLAN_A;
                end
            end

            S_PLAN_A:
            begin
                // Capacity bound, saturated to the largest frame index
                lim_next   = (lim_sum >= {1'b0, FRAME_MAX}) ? FRAME_MAX : lim_sum[FRAME_W-1:0];
                state_next = S_PLAN_B;
            end

            S_PLAN_B:
            begin
                stop_next  = (f1_reg < PROD_W'(lim_reg)) ? f1_reg[FRAME_W-1:0] : lim_reg;
                ovf_next   = (f1_reg > PROD_W'(lim_reg));
                state_next = S_PLAN_C;
            end

            S_PLAN_C:
            begin
                if (fs_w < PROD_W'(stop_reg))
                begin
                    f_next     = fs_w[FRAME_W-1:0];
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_WUPD;
                end
            end

            S_FILL:
            begin
                // Gap frames get 0, window frames the current flag
                mem_we    = 1'b1;
                mem_wdata = (PROD_W'(f_reg) < f0_reg) ? 1'b0 : speech_reg;
                f_next    = f_reg + FRAME_W'(1);
                if ((f_reg + FRAME_W'(1)) == stop_reg)
                begin
                    state_next = S_WUPD;
                end
            end

            S_WUPD:
            begin
                if (stop_reg > end_reg)
                begin
                    end_next = stop_reg;
                end
                if (speech_reg && (f1_reg > f0_reg))
                begin
                    last_next = (f1m1 > PROD_W'(FRAME_MAX)) ? FRAME_MAX
                                                            : f1m1[FRAME_W-1:0];
                    seen_next = 1'b1;
                end
                wcnt_next  = wcnt_reg + FRAME_W'(1);
                state_next = S_FINISH;
            end

            S_QRD:
            begin
                q_next     = mem_rdata;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // Load the result once the output slot is free
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next  = 1'b1;
                    oq_next      = q_reg;
                    ospeech_next = speech_reg;
                    oovf_next    = ovf_reg;
                    oseen_next   = seen_reg;
                    olast_next   = last_reg;
                    ostart_next  = base_reg;
                    oend_next    = end_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            speech_reg <= 1'b0;
            wcnt_reg   <= '0;
            base_reg   <= '0;
            end_reg    <= '0;
            last_reg   <= '0;
            seen_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            speech_reg <= speech_next;
            wcnt_reg   <= wcnt_next;
            base_reg   <= base_next;
            end_reg    <= end_next;
            last_reg   <= last_next;
            seen_reg   <= seen_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        prob_reg    <= prob_next;
        g_reg       <= g_next;
        f0_reg      <= f0_next;
        f1_reg      <= f1_next;
        lim_reg     <= lim_next;
        stop_reg    <= stop_next;
        f_reg       <= f_next;
        q_reg       <= q_next;
        ovf_reg     <= ovf_next;
        oq_reg      <= oq_next;
        ospeech_reg <= ospeech_next;
        oovf_reg    <= oovf_next;
        oseen_reg   <= oseen_next;
        olast_reg   <= olast_next;
        ostart_reg  <= ostart_next;
        oend_reg    <= oend_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            onset_reg  <= ONSET_RST;
            offset_reg <= OFFSET_RST;
            hop_reg    <= HOP_RST;
            win_reg    <= WIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ONSET:  onset_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_OFFSET: offset_reg <= cfg_data[LEVEL_W-1:0];
                CFG_HOP:    hop_reg    <= cfg_data[SAMP_W-1:0];
                CFG_WINDOW: win_reg    <= cfg_data[SAMP_W-1:0];
                default:    ;
            endcase
        end
    end

    assign req.ready             = (state_reg == S_IDLE);
    assign rsp.valid             = ovalid_reg;
    assign rsp.query_speech      = oq_reg;
    assign rsp.in_speech         = ospeech_reg;
    assign rsp.overflow          = oovf_reg;
    assign rsp.last_speech_valid = oseen_reg;
    assign rsp.last_speech_frame = olast_reg;
    assign rsp.timeline_start    = ostart_reg;
    assign rsp.timeline_end      = oend_reg;

    // Stored range never inverts
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg <= end_reg)
        else $error("timeline start beyond timeline end");

    // Stored range never exceeds the ring depth
    a_range_depth: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, end_reg} - {1'b0, base_reg}) <= DEPTH_33)
        else $error("timeline holds more frames than the store");

    // Divider completes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV0 || state_reg == S_DIV1))
        else $error("divider result with no waiting state");

    // Last speech frame stays zero until a speech frame is recorded
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (last_reg == '0))
        else $error("last speech frame set without a speech frame");
endmodule
